// File: design/ipde_pkg.sv
// Shared types and constants for the IR pulse dictionary encoder.
// No dependencies; used by every other file of the block.
`default_nettype none

package ipde_pkg;

  localparam int TICKS_W  = 16;
  localparam int DUR_W    = 17;
  localparam int LETTER_W = 5;

  localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

  localparam int TICK_US_DEF   = 2;
  localparam int DICT_SIZE_DEF = 26;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // take the input word
    logic step;     // advance the table scan by one entry
    logic capture;  // latch the scan outcome
    logic emit;     // write the result word and update the table
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;     // nothing to search for the word being loaded
    logic found;     // entry under compare matches
    logic stop;      // zero entry or last filled entry reached
    logic out_free;  // output register can take a word this cycle
  } status_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

// File: design/ipde_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on ipde_pkg for the address width helper.
`default_nettype none

module ipde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [ipde_pkg::addr_w(DEPTH)-1:0]     waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [ipde_pkg::addr_w(DEPTH)-1:0]     raddr,
  output logic [WIDTH-1:0]                       rdata
);
  import ipde_pkg::*;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: design/ipde_ctrl.sv
// Sequencer for the encoder: accept, table scan, result hand-off.
// Depends on ipde_pkg (state_t, cmd_t, status_t).
`default_nettype none

module ipde_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ipde_pkg::status_t status,
  output ipde_pkg::cmd_t    cmd
);
  import ipde_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.empty ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.found || status.stop) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.capture = status.found || status.stop;
        cmd.step    = !(status.found || status.stop);
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/ipde_dp.sv
// Datapath: scaling, dictionary RAM, scan index, fill count, parity, output register.
// Depends on ipde_pkg and ipde_ram.
`default_nettype none

module ipde_dp #(
  parameter int TICK_US   = ipde_pkg::TICK_US_DEF,
  parameter int DICT_SIZE = ipde_pkg::DICT_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ipde_pkg::cmd_t                 cmd,
  output ipde_pkg::status_t              status,
  input  logic [ipde_pkg::TICKS_W-1:0]   in_ticks,
  input  logic                           in_start_req,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_is_letter,
  output logic                           out_is_mark,
  output logic [ipde_pkg::LETTER_W-1:0]  out_letter,
  output logic [ipde_pkg::DUR_W-1:0]     out_duration_us
);
  import ipde_pkg::*;

  localparam int ADDR_W = addr_w(DICT_SIZE);
  localparam int CNT_W  = $clog2(DICT_SIZE + 1);
  localparam int MUL_W  = TICKS_W + $clog2(TICK_US + 1);

  // control state
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  used_r,      used_nxt;
  logic              parity_r,    parity_nxt;

  // item payload
  logic [DUR_W-1:0]  dur_r;
  logic              mark_r;
  logic              hit_r;
  logic [ADDR_W-1:0] cmp_idx_r;

  logic [LETTER_W-1:0] letter_r;
  logic [DUR_W-1:0]    dur_out_r;
  logic                is_letter_r;
  logic                is_mark_r;

  logic [MUL_W-1:0]  scaled;
  logic [DUR_W-1:0]  dur_sat;
  logic              mark_in;
  logic [DUR_W-1:0]  rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              last;
  logic              ram_we;

  assign scaled  = MUL_W'(in_ticks) * MUL_W'(TICK_US);
  assign dur_sat = (scaled > MUL_W'(DUR_MAX)) ? DUR_MAX : DUR_W'(scaled);
  assign mark_in = in_start_req | parity_r;

  // entry under compare is the last one filled
  assign last = ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == used_r);

  // address 0 is read in the load cycle so its data is ready on the first scan cycle
  always_comb begin
    if (cmd.load) begin
      rd_addr = '0;
    end else if (last) begin
      rd_addr = cmp_idx_r;
    end else begin
      rd_addr = cmp_idx_r + ADDR_W'(1);
    end
  end

  assign ram_we = cmd.emit && !hit_r && (used_r < CNT_W'(DICT_SIZE));

  ipde_ram #(
    .WIDTH (DUR_W),
    .DEPTH (DICT_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (used_r[ADDR_W-1:0]),
    .wdata (dur_r),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign status.empty    = in_start_req || (used_r == '0);
  assign status.found    = (rd_data == dur_r) && (rd_data != '0);
  assign status.stop     = (rd_data == '0) || last;
  assign status.out_free = !out_valid_r || out_ready;

  always_comb begin
    used_nxt      = used_r;
    parity_nxt    = parity_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      parity_nxt = !mark_in;
      if (in_start_req) begin
        used_nxt = '0;
      end
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (ram_we) begin
        used_nxt = used_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      used_r      <= '0;
      parity_r    <= 1'b1;
    end else begin
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      parity_r    <= parity_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dur_r     <= dur_sat;
      mark_r    <= mark_in;
      hit_r     <= 1'b0;
      cmp_idx_r <= '0;
    end
    if (cmd.step) begin
      cmp_idx_r <= cmp_idx_r + ADDR_W'(1);
    end
    if (cmd.capture) begin
      hit_r <= status.found;
    end
    if (cmd.emit) begin
      is_letter_r <= hit_r;
      is_mark_r   <= mark_r;
      letter_r    <= hit_r ? LETTER_W'(cmp_idx_r) : '0;
      dur_out_r   <= dur_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_letter   = is_letter_r;
  assign out_is_mark     = is_mark_r;
  assign out_letter      = letter_r;
  assign out_duration_us = dur_out_r;

endmodule

`default_nettype wire

// File: design/ir_pulse_dictionary_encoder_top.sv
// IR pulse dictionary encoder: one result word per input word.
// A new word is taken only once the previous result word is in the output register.
// The table scan, up to DICT_SIZE entries, uses the single RAM read port,
// one dictionary entry compared per cycle.
// Reset (rst_n low, synchronous): table empty, next word is a mark, no result pending.
// Depends on ipde_pkg, ipde_ctrl, ipde_dp, ipde_ram.
`default_nettype none

module ir_pulse_dictionary_encoder_top #(
  parameter int TICK_US   = ipde_pkg::TICK_US_DEF,
  parameter int DICT_SIZE = ipde_pkg::DICT_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ipde_pkg::TICKS_W-1:0]   in_ticks,
  input  logic                           in_start_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_is_letter,
  output logic                           out_is_mark,
  output logic [ipde_pkg::LETTER_W-1:0]  out_letter,
  output logic [ipde_pkg::DUR_W-1:0]     out_duration_us
);
  import ipde_pkg::*;

  cmd_t    cmd;
  status_t status;

  ipde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ipde_dp #(
    .TICK_US   (TICK_US),
    .DICT_SIZE (DICT_SIZE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_ticks        (in_ticks),
    .in_start_req    (in_start_req),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_is_letter   (out_is_letter),
    .out_is_mark     (out_is_mark),
    .out_letter      (out_letter),
    .out_duration_us (out_duration_us)
  );

endmodule

`default_nettype wire

// File: design/ipde_checker.sv
// Port-level checks for the encoder top, attached by bind.
// Depends on ipde_pkg and ir_pulse_dictionary_encoder_top.
`default_nettype none

module ipde_checker (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  input  wire                           in_ready,
  input  wire                           out_valid,
  input  wire                           out_ready,
  input  wire                           out_is_letter,
  input  wire                           out_is_mark,
  input  wire [ipde_pkg::LETTER_W-1:0]  out_letter,
  input  wire [ipde_pkg::DUR_W-1:0]     out_duration_us
);
  import ipde_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word pending right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duration_us)
      && $stable(out_letter) && $stable(out_is_letter) && $stable(out_is_mark))
    else $error("stalled result word changed");

  a_literal_letter_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_letter |-> out_letter == '0)
    else $error("literal word carries a letter index");

  // zero ends every search, so it can never be a dictionary hit
  a_letter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_letter |-> out_duration_us != '0)
    else $error("letter emitted for a zero duration");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

endmodule

bind ir_pulse_dictionary_encoder_top ipde_checker u_ipde_checker (.*);

`default_nettype wire
